// ----- design/lgge_pkg.sv -----
package lgge_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  // Size registers and scan counters (must hold the maximum itself)
  localparam int DIM_W      = 8;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  // Request codes
  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // One scan position issued to the generation pipeline
  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             in_row;
    logic             in_col;
  } scan_t;

  // Cell write of the new generation
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              data;
  } cell_wr_t;

endpackage

// ----- design/lgge_window.sv -----
module lgge_window
  import lgge_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  scan_t    scan,
  input  logic     src_bit,
  output cell_wr_t wr,
  output logic     busy
);

  // Line buffer: bit 0 holds the previous row, bit 1 the row before it
  logic [1:0] lbuf [MAX_WIDTH];
  logic [1:0] lbuf_q;

  scan_t      scan1;
  scan_t      scan2;
  logic [2:0] win_l;
  logic [2:0] win_c;
  logic [2:0] win_r;

  logic       x_cur;
  logic       x_up1;
  logic       x_up2;
  logic [2:0] col_vec;

  logic [3:0]       ncount;
  logic [8:0]       win_bits;
  logic             center;
  logic [DIM_W-1:0] out_row;
  logic [DIM_W-1:0] out_col;

  // Line buffer memory, read at issue, written in stage 1
  always_ff @(posedge clk) begin
    lbuf_q <= lbuf[scan.col[COL_W-1:0]];
    if (scan1.valid && scan1.in_col) begin
      lbuf[scan1.col[COL_W-1:0]] <= {lbuf_q[0], x_cur};
    end
  end

  // Stage 1: column of three cells, rows outside the grid read dead
  always_comb begin
    x_cur   = src_bit & scan1.in_row;
    x_up1   = lbuf_q[0] & (scan1.row != '0);
    x_up2   = lbuf_q[1] & (scan1.row > DIM_W'(1));
    col_vec = scan1.in_col ? {x_up2, x_up1, x_cur} : 3'b000;
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan1.valid <= 1'b0;
      scan2.valid <= 1'b0;
    end else begin
      scan1.valid <= scan.valid;
      scan2.valid <= scan1.valid;
    end
  end

  // Pipeline payload and 3x3 window; a new row starts with dead columns
  always_ff @(posedge clk) begin
    scan1.row    <= scan.row;
    scan1.col    <= scan.col;
    scan1.in_row <= scan.in_row;
    scan1.in_col <= scan.in_col;
    scan2.row    <= scan1.row;
    scan2.col    <= scan1.col;
    scan2.in_row <= scan1.in_row;
    scan2.in_col <= scan1.in_col;
    if (scan1.valid) begin
      if (scan1.col == '0) begin
        win_l <= 3'b000;
        win_c <= 3'b000;
      end else begin
        win_l <= win_c;
        win_c <= win_r;
      end
      win_r <= col_vec;
    end
  end

  // Stage 2: rule for the cell centered in the window
  always_comb begin
    win_bits = {win_l, win_c, win_r};
    center   = win_c[1];
    ncount   = 4'd0;
    for (int k = 0; k < 9; k++) begin
      ncount = ncount + {3'b000, win_bits[k]};
    end
    ncount  = ncount - {3'b000, center};
    out_row = scan2.row - DIM_W'(1);
    out_col = scan2.col - DIM_W'(1);
    wr.en   = scan2.valid && (scan2.row != '0) && (scan2.col != '0);
    wr.addr = {out_row[ROW_W-1:0], out_col[COL_W-1:0]};
    wr.data = (ncount == BIRTH_COUNT) || (center && (ncount == SURVIVE_LOW));
  end

  assign busy = scan1.valid | scan2.valid;

endmodule

// ----- design/life_grid_generation_engine_top.sv -----
// Game of Life engine (B3/S23) on a one-bit grid of up to 128 x 128 cells, held in two
// single-port-write memory banks that swap after each generation. After reset the engine
// clears the live bank and takes no request meanwhile. A set, an out-of-range request or
// an unused request type loads its result at acceptance; a valid read first reads the
// live bank and loads the result from its registered output. A step scans (height+1) x
// (width+1) positions at one cell per cycle, paced by the single read port of the live
// bank, and answers once the generation pipeline has drained. One request is in work
// at a time; a result waits in an output register, and the next request is taken only
// once that register is empty or is being read in the same cycle.
module life_grid_generation_engine_top
  import lgge_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // req_type[1:0], col[8:2], row[15:9], cell_value[16]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // read_value[0], status[1]
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [DIM_W-1:0]  used_w;
  logic [DIM_W-1:0]  used_h;
  logic              live_sel;
  logic [ADDR_W-1:0] clr_cnt;
  logic [DIM_W-1:0]  scan_row;
  logic [DIM_W-1:0]  scan_col;

  // Request fields
  logic [1:0]       req_type;
  logic [COL_W-1:0] req_col;
  logic [ROW_W-1:0] req_row;
  logic             req_value;
  logic             in_fire;
  logic             in_range;
  logic             scan_last;

  // Memory ports
  logic              bank_a [CELL_COUNT];
  logic              bank_b [CELL_COUNT];
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_a_q;
  logic              rd_b_q;
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic              a_wdata;
  logic              b_we;
  logic [ADDR_W-1:0] b_waddr;
  logic              b_wdata;

  scan_t    scan;
  cell_wr_t gen_wr;
  logic     gen_busy;

  logic out_load;
  logic out_read_value;
  logic out_status;
  logic out_valid;
  logic res_read_value;
  logic res_status;

  assign req_type  = s_tdata[1:0];
  assign req_col   = s_tdata[8:2];
  assign req_row   = s_tdata[15:9];
  assign req_value = s_tdata[16];

  assign used_w    = (grid_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width;
  assign used_h    = (grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height;
  assign in_range  = ({1'b0, req_col} < used_w) && ({1'b0, req_row} < used_h);
  assign scan_last = (scan_row == used_h) && (scan_col == used_w);

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign in_fire  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, res_status, res_read_value};

  // Generation pipeline: window, line buffer and rule
  lgge_window u_window (
    .clk     (clk),
    .rst     (rst),
    .scan    (scan),
    .src_bit (live_sel ? rd_b_q : rd_a_q),
    .wr      (gen_wr),
    .busy    (gen_busy)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_STEP) begin
            state_next = ST_SCAN;
          end else if (req_type == REQ_READ && in_range) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!gen_busy) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory controls and results
  always_comb begin
    rd_addr        = {req_row, req_col};
    a_we           = 1'b0;
    a_waddr        = {req_row, req_col};
    a_wdata        = req_value;
    b_we           = 1'b0;
    b_waddr        = {req_row, req_col};
    b_wdata        = req_value;
    scan           = '0;
    out_load       = 1'b0;
    out_read_value = 1'b0;
    out_status     = 1'b0;
    case (state)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_cnt;
        a_wdata = 1'b0;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_SET: begin
              out_load   = 1'b1;
              out_status = !in_range;
              if (in_range) begin
                a_we = !live_sel;
                b_we = live_sel;
              end
            end
            REQ_READ: begin
              out_load   = !in_range;
              out_status = 1'b1;
            end
            REQ_STEP: ;
            default:  out_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_load       = 1'b1;
        out_read_value = live_sel ? rd_b_q : rd_a_q;
      end
      ST_SCAN: begin
        scan.valid  = 1'b1;
        scan.row    = scan_row;
        scan.col    = scan_col;
        scan.in_row = scan_row < used_h;
        scan.in_col = scan_col < used_w;
        rd_addr     = {scan_row[ROW_W-1:0], scan_col[COL_W-1:0]};
      end
      ST_DRAIN: begin
        out_load = !gen_busy;
      end
      default: ;
    endcase
    // New generation goes to the spare bank
    if (gen_wr.en) begin
      if (live_sel) begin
        a_we    = 1'b1;
        a_waddr = gen_wr.addr;
        a_wdata = gen_wr.data;
      end else begin
        b_we    = 1'b1;
        b_waddr = gen_wr.addr;
        b_wdata = gen_wr.data;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      grid_width  <= DIM_W'(128);
      grid_height <= DIM_W'(128);
      live_sel    <= 1'b0;
      clr_cnt     <= '0;
      scan_row    <= '0;
      scan_col    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) grid_width <= cfg_data;
        if (cfg_index == CFG_HEIGHT) grid_height <= cfg_data;
      end
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
      // Raster scan over the grid plus one trailing row and column
      if (in_fire) begin
        scan_row <= '0;
        scan_col <= '0;
      end else if (state == ST_SCAN) begin
        if (scan_col == used_w) begin
          scan_col <= '0;
          scan_row <= scan_row + DIM_W'(1);
        end else begin
          scan_col <= scan_col + DIM_W'(1);
        end
      end
      if (state == ST_DRAIN && !gen_busy) live_sel <= !live_sel;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_read_value <= out_read_value;
      res_status     <= out_status;
    end
  end

  // Cell banks, registered read
  always_ff @(posedge clk) begin
    if (a_we) bank_a[a_waddr] <= a_wdata;
    rd_a_q <= bank_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bank_b[b_waddr] <= b_wdata;
    rd_b_q <= bank_b[rd_addr];
  end

  // A request is taken only when the result register is free or being emptied
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
    else $error("request accepted while result register full");

  // A generation never writes the bank it reads
  a_step_spare: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DRAIN) |-> !(live_sel ? b_we : a_we))
    else $error("generation write into live bank");

  // Banks swap only at the end of a generation, together with its result
  a_swap_end: assert property (@(posedge clk) disable iff (rst)
    (live_sel != $past(live_sel)) |-> ($past(state == ST_DRAIN) && m_tvalid))
    else $error("bank swap outside generation end");

endmodule

// ----- dv/life_grid_generation_engine_top_tb.sv -----
module life_grid_generation_engine_top_tb;
  import lgge_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [6:0] col;
    logic [6:0] row;
    logic       val;
  } grid_req_t;

  typedef struct packed {
    logic rd;
    logic st;
  } grid_rsp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  // Shadow copy of the engine state
  bit               cells [2][CELL_COUNT];
  bit               live_sel;
  logic [DIM_W-1:0] shadow_w = 8'd128;
  logic [DIM_W-1:0] shadow_h = 8'd128;

  grid_req_t req_q [$];
  grid_rsp_t rsp_q [$];
  grid_req_t cur_req;
  int        send_gap = 0;
  int        recv_stall = 0;
  bit        no_idle = 0;
  int        errors = 0;
  int        n_set = 0, n_read = 0, n_step = 0, n_oor = 0, n_rsp = 0;

  life_grid_generation_engine_top u_dut (.*);

  always #2 clk = ~clk;

  function automatic int used_w();
    return (shadow_w > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_w);
  endfunction

  function automatic int used_h();
    return (shadow_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_h);
  endfunction

  // One B3/S23 generation from the live copy into the spare copy
  task automatic advance_generation();
    int w, h, n, rr, cc;
    bit src_sel;
    w = used_w();
    h = used_h();
    src_sel = live_sel;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
              n += cells[src_sel][rr*MAX_WIDTH + cc];
          end
        end
        if (cells[src_sel][r*MAX_WIDTH + c])
          cells[!src_sel][r*MAX_WIDTH + c] = (n == SURVIVE_LOW || n == BIRTH_COUNT);
        else
          cells[!src_sel][r*MAX_WIDTH + c] = (n == BIRTH_COUNT);
      end
    end
    live_sel = !live_sel;
  endtask

  // Expected response of one accepted request
  task automatic predict_response(input grid_req_t q, output grid_rsp_t p);
    int a;
    p = '0;
    a = q.row * MAX_WIDTH + q.col;
    case (q.req)
      REQ_STEP: begin
        advance_generation();
        n_step++;
      end
      REQ_SET, REQ_READ: begin
        if (q.col >= used_w() || q.row >= used_h()) begin
          p.st = 1'b1;
          n_oor++;
        end else if (q.req == REQ_SET) begin
          cells[live_sel][a] = q.val;
          n_set++;
        end else begin
          p.rd = cells[live_sel][a];
          n_read++;
        end
      end
      default: ;
    endcase
  endtask

  // Request driver
  always @(posedge clk) begin
    grid_rsp_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid && s_tready) begin
        predict_response(cur_req, p);
        rsp_q.push_back(p);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        s_tdata  <= {7'b0, cur_req.val, cur_req.row, cur_req.col, cur_req.req};
        s_tvalid <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 13);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Response monitor with random back-pressure
  always @(posedge clk) begin
    grid_rsp_t e;
    int s;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      n_rsp++;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response %b", $realtime, m_tdata[1:0]);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (m_tdata[0] !== e.rd) begin
          $display("%0t: read_value expected %b actual %b", $realtime, e.rd, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== e.st) begin
          $display("%0t: status expected %b actual %b", $realtime, e.st, m_tdata[1]);
          errors++;
        end
      end
      s = no_idle ? 0 : $urandom_range(0, 13);
      recv_stall <= s;
      m_tready <= (s == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready <= (recv_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic grid_req_t mk(logic [1:0] rq, int c, int r, bit v);
    grid_req_t q;
    q.req = rq;
    q.col = c[6:0];
    q.row = r[6:0];
    q.val = v;
    return q;
  endfunction

  // Random request biased into the grid in use
  function automatic grid_req_t rand_req();
    int w, h, k, c, r;
    logic [1:0] rq;
    w = used_w();
    h = used_h();
    k = $urandom_range(0, 99);
    if (k < 45) rq = REQ_SET;
    else if (k < 80) rq = REQ_READ;
    else if (k < 95) rq = (w * h > 2000 && $urandom_range(0, 5) != 0) ? REQ_READ : REQ_STEP;
    else rq = REQ_UNUSED;
    if (w > 0 && h > 0 && $urandom_range(0, 4) != 0) begin
      c = $urandom_range(0, w - 1);
      r = $urandom_range(0, h - 1);
    end else begin
      c = $urandom_range(0, 127);
      r = $urandom_range(0, 127);
    end
    return mk(rq, c, r, $urandom_range(0, 2) != 0);
  endfunction

  // Wait until every request is sent and answered
  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || s_tvalid || rsp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(logic idx, logic [DIM_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == CFG_WIDTH) shadow_w = v;
    else shadow_h = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int count);
    drain();
    write_size(CFG_WIDTH, w);
    write_size(CFG_HEIGHT, h);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) req_q.push_back(rand_req());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Full grid: first step writes every cell of the spare bank
    req_q.push_back(mk(REQ_SET, 0, 0, 1));
    req_q.push_back(mk(REQ_SET, 127, 127, 1));
    req_q.push_back(mk(REQ_READ, 0, 0, 0));
    req_q.push_back(mk(REQ_READ, 127, 127, 0));
    req_q.push_back(mk(REQ_READ, 85, 42, 0));
    req_q.push_back(mk(REQ_UNUSED, 127, 127, 1));
    req_q.push_back(mk(REQ_STEP, 0, 0, 0));
    req_q.push_back(mk(REQ_READ, 0, 0, 0));
    drain();
    // Blinker on a 5 x 4 grid, plus out-of-range positions
    write_size(CFG_WIDTH, 8'd5);
    write_size(CFG_HEIGHT, 8'd4);
    for (int c = 1; c <= 3; c++) req_q.push_back(mk(REQ_SET, c, 1, 1));
    req_q.push_back(mk(REQ_STEP, 0, 0, 0));
    for (int r = 0; r <= 2; r++) req_q.push_back(mk(REQ_READ, 2, r, 0));
    req_q.push_back(mk(REQ_SET, 5, 0, 1));
    req_q.push_back(mk(REQ_READ, 0, 4, 0));
    req_q.push_back(mk(REQ_STEP, 0, 0, 0));
    req_q.push_back(mk(REQ_READ, 1, 1, 0));
    drain();
    // Zero width: nothing in use, step still swaps
    write_size(CFG_WIDTH, 8'd0);
    req_q.push_back(mk(REQ_SET, 0, 0, 1));
    req_q.push_back(mk(REQ_READ, 0, 0, 0));
    req_q.push_back(mk(REQ_STEP, 0, 0, 0));
    // Random phases over several sizes, saturation and extremes included
    run_phase(8'd255, 8'd3, 10);
    run_phase(8'd5, 8'd0, 6);
    run_phase(8'd1, 8'd1, 8);
    run_phase(8'd8, 8'd8, 16);
    run_phase(8'd16, 8'd12, 16);
    run_phase(8'd3, 8'd255, 10);
    run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)), 16);
    run_phase(8'd128, 8'd128, 12);
    drain();
    repeat (30) @(posedge clk);
    $display("Covered %0d sets, %0d reads, %0d steps, %0d out-of-range, %0d responses",
             n_set, n_read, n_step, n_oor, n_rsp);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
design/lgge_pkg.sv
design/lgge_window.sv
design/life_grid_generation_engine_top.sv
dv/life_grid_generation_engine_top_tb.sv
